[rtl/ffpa_pkg.sv]
`default_nettype none

package ffpa_pkg;

    localparam int MAX_BLOCKS_DEF = 64;

    localparam int CMD_W   = 1;
    localparam int BIDX_W  = 6;
    localparam int AMT_W   = 16;
    localparam int JOB_W   = 16;
    localparam int BCNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BIDX_W-1:0] block_index;
        logic [AMT_W-1:0]  amount;
    } t_in;

    typedef struct packed {
        logic              allocated;
        logic [JOB_W-1:0]  job_number;
        logic [BIDX_W-1:0] chosen_block;
        logic [AMT_W-1:0]  fragment;
    } t_out;

    // one partition entry: used mark beside the partition size
    typedef struct packed {
        logic             used;
        logic [AMT_W-1:0] size;
    } t_entry;

endpackage

`default_nettype wire

[rtl/first_fit_partition_allocator.sv]
// First-fit fixed-partition allocator.
// Input channel (i_in_valid / o_in_stall, payload i_in): a load word writes one
// partition size and frees that partition; an allocate word carries a job size.
// Output channel (o_out_valid / i_out_stall, payload o_out): one word per
// allocate: job number, allocated flag, chosen partition and fragmentation.
// i_cfg_we / i_cfg_data set block_count, the number of partitions scanned
// (saturated to MAX_BLOCKS); write it only while the block is idle.
// A load writes the memory without leaving the idle state, so the block is ready again on the next cycle.
// An allocate scans the partition memory one entry per cycle through its
// single read port, stopping at the first hit or after the last scanned
// partition: the result goes to a holding register (state DONE) and then to
// the output register, and no new word is taken in the meantime.
// The output register decouples the sides: a new word is accepted while a
// result waits; if the receiver stalls, the next result holds in the block
// (stalling the input) until the output register is taken.
// Synchronous reset clears the job counter, block_count and the output
// valid flag; partition sizes and used marks are undefined until loaded.
`default_nettype none

module first_fit_partition_allocator #(
    parameter int MAX_BLOCKS = ffpa_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire ffpa_pkg::t_in               i_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output ffpa_pkg::t_out                   o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [ffpa_pkg::BCNT_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [ffpa_pkg::BCNT_W-1:0] r_block_count;
    logic [CNT_W-1:0]            limit;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    ffpa_pkg::t_entry mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    ffpa_pkg::t_entry mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
        end else if (i_cfg_we) begin
            r_block_count <= i_cfg_data;
        end
    end

    // saturate the scan length to the partitions that exist
    assign limit = (int'(r_block_count) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                      : CNT_W'(r_block_count);

    ffpa_size_mem #(
        .DEPTH  (MAX_BLOCKS),
        .ADDR_W (IDX_W)
    ) u_size_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ffpa_scan #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_limit     (limit),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

[rtl/ffpa_size_mem.sv]
`default_nettype none

module ffpa_size_mem #(
    parameter int DEPTH  = ffpa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire ffpa_pkg::t_entry  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output ffpa_pkg::t_entry       o_rdata
);

    ffpa_pkg::t_entry r_mem [DEPTH];
    ffpa_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/ffpa_scan.sv]
`default_nettype none

module ffpa_scan #(
    parameter int MAX_BLOCKS = ffpa_pkg::MAX_BLOCKS_DEF,
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire ffpa_pkg::t_in              i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output ffpa_pkg::t_out                  o_out,
    input  wire logic [CNT_W-1:0]           i_limit,
    output logic                            o_mem_we,
    output logic      [IDX_W-1:0]           o_mem_waddr,
    output ffpa_pkg::t_entry                o_mem_wdata,
    output logic                            o_mem_re,
    output logic      [IDX_W-1:0]           o_mem_raddr,
    input  wire ffpa_pkg::t_entry           i_mem_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state                     r_state;
    logic [ffpa_pkg::JOB_W-1:0] r_job;
    logic [ffpa_pkg::AMT_W-1:0] r_amount;
    logic [CNT_W-1:0]           r_issue;
    logic                       r_chk_vld;
    logic [IDX_W-1:0]           r_chk_idx;
    ffpa_pkg::t_out             r_res;
    logic                       r_out_valid;
    ffpa_pkg::t_out             r_out;

    logic             in_acc;
    logic             load_ok;
    logic [IDX_W-1:0] load_idx;
    logic             issue;
    logic             hit;
    logic             fail;
    logic             out_free;

    always_comb begin
        in_acc   = i_in_valid && (r_state == ST_IDLE);
        load_idx = IDX_W'(i_in.block_index);
        load_ok  = in_acc && (i_in.command == ffpa_pkg::CMD_LOAD)
                   && (int'(i_in.block_index) < MAX_BLOCKS);
        issue    = (r_state == ST_SCAN) && (r_issue < i_limit);
        hit      = (r_state == ST_SCAN) && r_chk_vld && !i_mem_rdata.used
                   && (i_mem_rdata.size >= r_amount);
        fail     = (r_state == ST_SCAN) && !hit && (r_issue == i_limit);
        out_free = !r_out_valid || !i_out_stall;
        // a hit writes its used mark back; loads land only while idle
        o_mem_wdata.used = hit;
        o_mem_wdata.size = hit ? i_mem_rdata.size : i_in.amount;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_mem_we    = load_ok || hit;
    assign o_mem_waddr = hit ? r_chk_idx : load_idx;
    assign o_mem_re    = issue;
    assign o_mem_raddr = r_issue[IDX_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_job       <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in.command == ffpa_pkg::CMD_ALLOC)) begin
                        r_job     <= r_job + 1'b1;
                        r_amount  <= i_in.amount;
                        r_issue   <= '0;
                        r_chk_vld <= 1'b0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // read of entry k lands while entry k-1 is checked
                    r_chk_vld <= issue;
                    r_chk_idx <= r_issue[IDX_W-1:0];
                    if (issue) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (hit) begin
                        r_res.allocated    <= 1'b1;
                        r_res.job_number   <= r_job;
                        r_res.chosen_block <= ffpa_pkg::BIDX_W'(r_chk_idx);
                        r_res.fragment     <= i_mem_rdata.size - r_amount;
                        r_state            <= ST_DONE;
                    end else if (fail) begin
                        r_res.allocated    <= 1'b0;
                        r_res.job_number   <= r_job;
                        r_res.chosen_block <= '0;
                        r_res.fragment     <= '0;
                        r_state            <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_chk_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_chk_vld) |-> (CNT_W'(r_chk_idx) + 1'b1 == r_issue))
        else $error("checked entry is not the one issued last");

    a_job_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.command == ffpa_pkg::CMD_ALLOC) |=> (r_job == $past(r_job) + 1'b1))
        else $error("job counter did not advance on allocate");

    a_hit_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> (o_mem_we && o_mem_waddr == r_chk_idx && o_mem_wdata.used))
        else $error("taken partition not marked used");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.allocated) |->
        (r_out.chosen_block == '0 && r_out.fragment == '0))
        else $error("failed allocate carries nonzero block or fragment");

endmodule

`default_nettype wire
